>>> design/ps2mt_pkg.sv
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared types and constants for the PS/2 mouse cursor tracker: field widths,
// status and header bit positions, CSR indexes and reset values.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int COLUMN_W = 7;
   localparam int ROW_W    = 6;
   localparam int OFFSET_W = 14;

   // CSR port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_COLUMN = 1'b0,
      CSR_MAX_ROW    = 1'b1
   } csr_index_type;

   // Controller status bits
   localparam int STATUS_READY_BIT = 0;
   localparam int STATUS_AUX_BIT   = 5;

   // Header sign bits
   localparam int HDR_XSIGN_BIT = 4;
   localparam int HDR_YSIGN_BIT = 5;

   // Reset values
   localparam logic [COLUMN_W-1:0] MAX_COLUMN_RESET = 7'd79;
   localparam logic [ROW_W-1:0]    MAX_ROW_RESET    = 6'd24;
   localparam logic [COLUMN_W-1:0] COLUMN_RESET     = 7'd40;
   localparam logic [ROW_W-1:0]    ROW_RESET        = 6'd12;

   // Packet byte sequence
   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_XMOVE  = 2'd1,
      PH_YMOVE  = 2'd2
   } phase_type;

   // Halve a 9-bit two's complement movement, truncating toward zero.
   function automatic logic signed [BYTE_W-1:0] half_move(
      input logic [BYTE_W-1:0] low,
      input logic              neg
   );
      logic signed [BYTE_W:0] v;
      logic signed [BYTE_W:0] biased;
      begin
         v      = signed'({neg, low});
         biased = v + signed'({{BYTE_W{1'b0}}, neg});
         half_move = BYTE_W'(biased >>> 1);
      end
   endfunction

endpackage

>>> design/ps2mt_req_if.sv
// ----------------------------------------------------------------------------
// ps2mt_req_if
// Input channel: one controller status byte and one data byte per beat.
// ----------------------------------------------------------------------------
interface ps2mt_req_if;
   logic                           valid;
   logic                           ready;
   logic [ps2mt_pkg::BYTE_W-1:0]   status_byte;
   logic [ps2mt_pkg::BYTE_W-1:0]   data_byte;

   modport source (output valid, output status_byte, output data_byte, input ready);
   modport sink   (input valid, input status_byte, input data_byte, output ready);
endinterface

>>> design/ps2mt_rsp_if.sv
// ----------------------------------------------------------------------------
// ps2mt_rsp_if
// Result channel: packet completion flag, cursor cell and attribute offset.
// ----------------------------------------------------------------------------
interface ps2mt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             packet_done;
   logic [ps2mt_pkg::COLUMN_W-1:0]   cursor_column;
   logic [ps2mt_pkg::ROW_W-1:0]      cursor_row;
   logic [ps2mt_pkg::OFFSET_W-1:0]   attribute_offset;

   modport source (output valid, output packet_done, output cursor_column,
                   output cursor_row, output attribute_offset, input ready);
   modport sink   (input valid, input packet_done, input cursor_column,
                   input cursor_row, input attribute_offset, output ready);
endinterface

>>> design/ps2_mouse_cursor_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// Collects three-byte PS/2 mouse packets from controller beats, moves a text
// cursor by half the reported motion and reports the cursor cell and its
// attribute byte offset for every beat.
// ----------------------------------------------------------------------------
//
//  channel  direction  contents
//  -------  ---------  ---------------------------------------------------
//  req_bus  in         status_byte, data_byte (valid/ready)
//  rsp_bus  out        packet_done, cursor_column, cursor_row,
//                      attribute_offset (valid/ready)
//  csr_*    in         write enable, index (0 max_column, 1 max_row), data
//
//  Each beat is computed combinationally: state and the output register load at
//  the accepting edge, and the result can leave on the following edge. One
//  beat per cycle is sustained while rsp_bus.ready stays high; the cursor
//  add/clamp and the row * pitch multiply set the path. A new beat is taken
//  whenever the output register is empty or is being drained. Synchronous
//  reset restores cursor (40,12), limits (79,24).
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker (
   input  logic                                  clock,
   input  logic                                  reset,
   ps2mt_req_if.sink                             req_bus,
   ps2mt_rsp_if.source                           rsp_bus,
   input  logic                                  csr_we,
   input  logic [ps2mt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ps2mt_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ps2mt_pkg::*;

   localparam int POS_W = BYTE_W + 2;  // signed room for position +/- delta

   // Configuration
   logic [COLUMN_W-1:0] max_column_ff;
   logic [ROW_W-1:0]    max_row_ff;

   // Packet and cursor state
   phase_type           phase_ff, phase_in;
   logic [BYTE_W-1:0]   header_ff, header_in;
   logic [BYTE_W-1:0]   xmove_ff, xmove_in;
   logic [COLUMN_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0]    row_ff, row_in;

   // Output register
   logic                rsp_valid_ff;
   logic                done_ff, done_in;
   logic [COLUMN_W-1:0] rsp_column_ff;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff, offset_in;

   logic accept;
   logic byte_ok;

   logic signed [BYTE_W-1:0] dx, dy;
   logic signed [POS_W-1:0]  col_sum, row_sum;
   logic [COLUMN_W:0]        pitch;
   logic [OFFSET_W-1:0]      cell_index;

   // Handshake: output register parts the two sides
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign byte_ok       = req_bus.status_byte[STATUS_READY_BIT]
                       && req_bus.status_byte[STATUS_AUX_BIT];

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_column_ff <= MAX_COLUMN_RESET;
         max_row_ff    <= MAX_ROW_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_COLUMN: max_column_ff <= csr_wdata[COLUMN_W-1:0];
            CSR_MAX_ROW:    max_row_ff    <= csr_wdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Next packet phase
   always_comb begin
      phase_in = phase_ff;
      if (accept && byte_ok) begin
         unique case (phase_ff)
            PH_HEADER: phase_in = PH_XMOVE;
            PH_XMOVE:  phase_in = PH_YMOVE;
            default:   phase_in = PH_HEADER;
         endcase
      end
   end

   // Movement deltas and clamped cursor
   always_comb begin
      dx      = half_move(xmove_ff, header_ff[HDR_XSIGN_BIT]);
      dy      = half_move(req_bus.data_byte, header_ff[HDR_YSIGN_BIT]);
      col_sum = signed'(POS_W'(column_ff)) + POS_W'(dx);
      row_sum = signed'(POS_W'(row_ff)) - POS_W'(dy);

      header_in = header_ff;
      xmove_in  = xmove_ff;
      column_in = column_ff;
      row_in    = row_ff;
      done_in   = 1'b0;

      if (accept && byte_ok) begin
         unique case (phase_ff)
            PH_HEADER: header_in = req_bus.data_byte;
            PH_XMOVE:  xmove_in  = req_bus.data_byte;
            default: begin
               done_in = 1'b1;
               if (col_sum < 0)
                  column_in = '0;
               else if (col_sum > signed'(POS_W'(max_column_ff)))
                  column_in = max_column_ff;
               else
                  column_in = col_sum[COLUMN_W-1:0];
               if (row_sum < 0)
                  row_in = '0;
               else if (row_sum > signed'(POS_W'(max_row_ff)))
                  row_in = max_row_ff;
               else
                  row_in = row_sum[ROW_W-1:0];
            end
         endcase
      end
   end

   // Attribute offset: (row * pitch + column) * 2 + 1, modulo 2^14
   always_comb begin
      pitch      = {1'b0, max_column_ff} + (COLUMN_W+1)'(1);
      cell_index = OFFSET_W'(row_in) * OFFSET_W'(pitch) + OFFSET_W'(column_in);
      offset_in  = {cell_index[OFFSET_W-2:0], 1'b1};
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         header_ff <= '0;
         xmove_ff  <= '0;
         column_ff <= COLUMN_RESET;
         row_ff    <= ROW_RESET;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         xmove_ff  <= xmove_in;
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   // Output valid
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (req_bus.ready)
         rsp_valid_ff <= req_bus.valid;
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (accept) begin
         done_ff       <= done_in;
         rsp_column_ff <= column_in;
         rsp_row_ff    <= row_in;
         rsp_offset_ff <= offset_in;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.packet_done      = done_ff;
   assign rsp_bus.cursor_column    = rsp_column_ff;
   assign rsp_bus.cursor_row       = rsp_row_ff;
   assign rsp_bus.attribute_offset = rsp_offset_ff;

   // Checks
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted beat left no result");

   a_third_byte_done: assert property (@(posedge clock) disable iff (reset)
      (accept && byte_ok && phase_ff == PH_YMOVE) |=> (done_ff && phase_ff == PH_HEADER))
      else $error("third packet byte did not complete packet");

   a_cursor_holds: assert property (@(posedge clock) disable iff (reset)
      !(accept && byte_ok) |=> ($stable(column_ff) && $stable(row_ff)
                               && $stable(phase_ff)))
      else $error("cursor state moved without an accepted byte");

   a_done_only_on_third: assert property (@(posedge clock) disable iff (reset)
      (accept && !(byte_ok && phase_ff == PH_YMOVE)) |=> !done_ff)
      else $error("packet_done raised without a completing byte");

endmodule
